// ----- hdl/sbs_pkg.sv -----
// Shared types, constants and codes of the score byte-stream sequencer.
`default_nettype none
package sbs_pkg;

	localparam int SCORE_DEPTH = 4096;
	localparam int CMD_LIMIT   = 32;

	localparam int ADDR_W  = $clog2(SCORE_DEPTH);
	localparam int CMDC_W  = $clog2(CMD_LIMIT + 1);
	// worst case: sixteen note offs, then one event per command
	localparam int EV_DEPTH = 16 + CMD_LIMIT;
	localparam int EV_IDX_W = $clog2(EV_DEPTH);
	localparam int EV_CNT_W = $clog2(EV_DEPTH + 1);

	localparam logic [1:0] KIND_ON     = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic       CFG_VOLUME   = 1'b0;
	localparam logic       CFG_CHANNELS = 1'b1;
	localparam logic [4:0] CHANNEL_MAX  = 5'd16;

	localparam logic [7:0] HI_MASK     = 8'hf0;
	localparam logic [7:0] NIB_OFF     = 8'h80;
	localparam logic [7:0] NIB_ON      = 8'h90;
	localparam logic [7:0] NIB_INSTR   = 8'hc0;
	localparam logic [7:0] NIB_RESTART = 8'he0;
	localparam logic [7:0] NIB_STOP    = 8'hf0;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CLS_WAIT,
		CLS_OFF,
		CLS_ON,
		CLS_INSTR,
		CLS_RESTART,
		CLS_STOP,
		CLS_OTHER
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIL,
		ST_SETUP,
		ST_FETCH,
		ST_DECODE,
		ST_WAIT_LO,
		ST_NOTE,
		ST_DRAIN
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_SIL,
		DP_SIL_END,
		DP_SETUP,
		DP_FETCH,
		DP_DECODE,
		DP_WAIT_LO,
		DP_NOTE,
		DP_LIMIT,
		DP_DRAIN
	} dp_op_t;

	typedef struct packed {
		logic is_off;
		logic [3:0] chan;
		logic [7:0] note;
	} ev_t;

	typedef struct packed {
		op_t  op;
		logic playing;
		logic wait_one;
		logic sil_more;
		logic limit_hit;
		cls_t cls;
		logic ev_more;
	} sbs_stat_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		c = CLS_OTHER;
		if (!b[7])                          c = CLS_WAIT;
		else if ((b & HI_MASK) == NIB_OFF)     c = CLS_OFF;
		else if ((b & HI_MASK) == NIB_ON)      c = CLS_ON;
		else if ((b & HI_MASK) == NIB_INSTR)   c = CLS_INSTR;
		else if ((b & HI_MASK) == NIB_RESTART) c = CLS_RESTART;
		else if ((b & HI_MASK) == NIB_STOP)    c = CLS_STOP;
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/score_bytestream_sequencer.sv -----
// Top level of the score byte-stream sequencer: controller plus datapath.
// Steps of an item: accept; a silence of note offs for a stop or a start while playing;
// setup for a start; per command a fetch and decode, with a further byte read for note
// on and wait; a halt at the command limit; then a drain of buffered words and the status word.
// Throughput: one item at a time; busy drops with the status word, receiver cannot stall.
// Reset: cursor, start address, wait count and playing cleared; score memory undefined.
`default_nettype none
module score_bytestream_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel: accepted when start is high and busy is low
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [11:0] address,
	input  wire logic [7:0]  data,
	// configuration writes, taken while idle: the user must keep to this, the block does not enforce it
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	// result words, one per strobe cycle, cannot be held off
	output logic             strobe,
	output logic [1:0]       event_kind,
	output logic [3:0]       channel,
	output logic [7:0]       note,
	output logic             playing,
	output logic             overrun,
	output logic             last
);

	sbs_pkg::sbs_stat_t stat;
	sbs_pkg::dp_op_t    dp_op;

	// controller walks the score; it sees the item handshake, the opcode and datapath status
	sbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.dp_op  (dp_op),
		.busy   (busy)
	);

	// datapath buffers note events of an item so every word carries the
	// final playing and overrun flags, then drains them after the run
	sbs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.address    (address),
		.data       (data),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.dp_op      (dp_op),
		.stat       (stat),
		.strobe     (strobe),
		.event_kind (event_kind),
		.channel    (channel),
		.note       (note),
		.playing    (playing),
		.overrun    (overrun),
		.last       (last)
	);

endmodule
`default_nettype wire

// ----- hdl/sbs_ctrl.sv -----
// Sequencing state machine of the score byte-stream sequencer.
`default_nettype none
module sbs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        opcode,
	input  wire sbs_pkg::sbs_stat_t stat,
	output sbs_pkg::dp_op_t        dp_op,
	output logic                   busy
);

	sbs_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (start) begin
					case (sbs_pkg::op_t'(opcode))
						sbs_pkg::OP_START:
							state_nxt = stat.playing ? sbs_pkg::ST_SIL : sbs_pkg::ST_SETUP;
						sbs_pkg::OP_STOP:  state_nxt = sbs_pkg::ST_SIL;
						sbs_pkg::OP_TICK:
							state_nxt = (stat.playing && stat.wait_one) ?
								sbs_pkg::ST_FETCH : sbs_pkg::ST_DRAIN;
						default:           state_nxt = sbs_pkg::ST_DRAIN;
					endcase
				end
			end
			sbs_pkg::ST_SIL: begin
				if (!stat.sil_more) begin
					state_nxt = (stat.op == sbs_pkg::OP_START) ?
						sbs_pkg::ST_SETUP : sbs_pkg::ST_DRAIN;
				end
			end
			sbs_pkg::ST_SETUP: state_nxt = sbs_pkg::ST_FETCH;
			sbs_pkg::ST_FETCH: begin
				state_nxt = stat.limit_hit ? sbs_pkg::ST_DRAIN : sbs_pkg::ST_DECODE;
			end
			sbs_pkg::ST_DECODE: begin
				case (stat.cls)
					sbs_pkg::CLS_WAIT: state_nxt = sbs_pkg::ST_WAIT_LO;
					sbs_pkg::CLS_ON:   state_nxt = sbs_pkg::ST_NOTE;
					sbs_pkg::CLS_STOP: state_nxt = sbs_pkg::ST_DRAIN;
					default:           state_nxt = sbs_pkg::ST_FETCH;
				endcase
			end
			sbs_pkg::ST_WAIT_LO: state_nxt = sbs_pkg::ST_DRAIN;
			sbs_pkg::ST_NOTE:    state_nxt = sbs_pkg::ST_FETCH;
			sbs_pkg::ST_DRAIN: begin
				if (!stat.ev_more) state_nxt = sbs_pkg::ST_IDLE;
			end
			default: state_nxt = sbs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		dp_op = sbs_pkg::DP_NONE;
		busy  = 1'b1;
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) dp_op = sbs_pkg::DP_ACCEPT;
			end
			sbs_pkg::ST_SIL:
				dp_op = stat.sil_more ? sbs_pkg::DP_SIL : sbs_pkg::DP_SIL_END;
			sbs_pkg::ST_SETUP:   dp_op = sbs_pkg::DP_SETUP;
			sbs_pkg::ST_FETCH:
				dp_op = stat.limit_hit ? sbs_pkg::DP_LIMIT : sbs_pkg::DP_FETCH;
			sbs_pkg::ST_DECODE:  dp_op = sbs_pkg::DP_DECODE;
			sbs_pkg::ST_WAIT_LO: dp_op = sbs_pkg::DP_WAIT_LO;
			sbs_pkg::ST_NOTE:    dp_op = sbs_pkg::DP_NOTE;
			sbs_pkg::ST_DRAIN:   dp_op = sbs_pkg::DP_DRAIN;
			default:             dp_op = sbs_pkg::DP_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/sbs_datapath.sv -----
// Datapath: score memory, cursor, wait counter, event buffer and result stage.
`default_nettype none
module sbs_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        opcode,
	input  wire logic [11:0]       address,
	input  wire logic [7:0]        data,
	input  wire logic              cfg_write,
	input  wire logic              cfg_index,
	input  wire logic [4:0]        cfg_data,
	input  wire sbs_pkg::dp_op_t   dp_op,
	output sbs_pkg::sbs_stat_t     stat,
	output logic                   strobe,
	output logic [1:0]             event_kind,
	output logic [3:0]             channel,
	output logic [7:0]             note,
	output logic                   playing,
	output logic                   overrun,
	output logic                   last
);

	// score memory, registered read
	logic [7:0] score_mem [sbs_pkg::SCORE_DEPTH];
	logic [7:0] rd_q;

	// event buffer, registered read
	sbs_pkg::ev_t ev_mem [sbs_pkg::EV_DEPTH];
	sbs_pkg::ev_t ev_rd_q;

	sbs_pkg::addr_t cursor_q, start_q;
	logic [14:0] wait_q;
	logic [6:0]  wait_hi_q;
	logic        play_q, ovr_q;
	logic        vol_q;
	logic [4:0]  chcnt_q, ch_q, ch_lim;
	logic [3:0]  on_chan_q;
	logic [sbs_pkg::CMDC_W-1:0]   cmd_cnt_q;
	logic [sbs_pkg::EV_CNT_W-1:0] ev_cnt_q, ev_ptr_q;
	sbs_pkg::op_t op_q;
	sbs_pkg::cls_t cls;

	logic        rd_en;
	logic        ev_we;
	sbs_pkg::ev_t ev_wdata;
	logic [14:0] wait_val;

	logic out_ev_s1, out_st_s1, play_s1, ovr_s1;

	assign ch_lim   = (chcnt_q > sbs_pkg::CHANNEL_MAX) ? sbs_pkg::CHANNEL_MAX : chcnt_q;
	assign cls      = sbs_pkg::classify(rd_q);
	assign wait_val = {wait_hi_q, rd_q};

	assign stat.op        = op_q;
	assign stat.playing   = play_q;
	assign stat.wait_one  = (wait_q == 15'd1);
	assign stat.sil_more  = (ch_q < ch_lim);
	assign stat.limit_hit = (cmd_cnt_q == sbs_pkg::CMDC_W'(sbs_pkg::CMD_LIMIT));
	assign stat.cls       = cls;
	assign stat.ev_more   = (ev_ptr_q != ev_cnt_q);

	// reads at the cursor: command fetch, low wait byte, note byte
	assign rd_en = (dp_op == sbs_pkg::DP_FETCH) ||
		((dp_op == sbs_pkg::DP_DECODE) &&
		 ((cls == sbs_pkg::CLS_WAIT) || (cls == sbs_pkg::CLS_ON)));

	always_comb begin
		ev_we    = 1'b0;
		ev_wdata = '0;
		case (dp_op)
			sbs_pkg::DP_SIL: begin
				ev_we = 1'b1;
				ev_wdata.is_off = 1'b1;
				ev_wdata.chan   = ch_q[3:0];
			end
			sbs_pkg::DP_DECODE: begin
				if (cls == sbs_pkg::CLS_OFF) begin
					ev_we = 1'b1;
					ev_wdata.is_off = 1'b1;
					ev_wdata.chan   = rd_q[3:0];
				end
			end
			sbs_pkg::DP_NOTE: begin
				ev_we = 1'b1;
				ev_wdata.chan = on_chan_q;
				ev_wdata.note = rd_q;
			end
			default: ev_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_op == sbs_pkg::DP_ACCEPT && sbs_pkg::op_t'(opcode) == sbs_pkg::OP_LOAD) begin
			score_mem[sbs_pkg::ADDR_W'(address)] <= data;
		end
		if (rd_en) rd_q <= score_mem[cursor_q];
	end

	always_ff @(posedge clk) begin
		if (ev_we) ev_mem[ev_cnt_q[sbs_pkg::EV_IDX_W-1:0]] <= ev_wdata;
		if (dp_op == sbs_pkg::DP_DRAIN && stat.ev_more) begin
			ev_rd_q <= ev_mem[ev_ptr_q[sbs_pkg::EV_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_op == sbs_pkg::DP_ACCEPT) op_q <= sbs_pkg::op_t'(opcode);
		if (dp_op == sbs_pkg::DP_DECODE) begin
			wait_hi_q <= rd_q[6:0];
			on_chan_q <= rd_q[3:0];
		end
		if (dp_op == sbs_pkg::DP_DRAIN) begin
			play_s1 <= play_q;
			ovr_s1  <= ovr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q   <= 1'b1;
			chcnt_q <= 5'd3;
		end else if (cfg_write) begin
			if (cfg_index == sbs_pkg::CFG_VOLUME) vol_q <= cfg_data[0];
			else                                  chcnt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			start_q   <= '0;
			wait_q    <= '0;
			play_q    <= 1'b0;
			ovr_q     <= 1'b0;
			ch_q      <= '0;
			cmd_cnt_q <= '0;
			ev_cnt_q  <= '0;
			ev_ptr_q  <= '0;
			out_ev_s1 <= 1'b0;
			out_st_s1 <= 1'b0;
		end else begin
			out_ev_s1 <= 1'b0;
			out_st_s1 <= 1'b0;
			if (rd_en) cursor_q <= cursor_q + 1'b1;
			if (ev_we) ev_cnt_q <= ev_cnt_q + 1'b1;
			case (dp_op)
				sbs_pkg::DP_ACCEPT: begin
					ovr_q     <= 1'b0;
					ch_q      <= '0;
					cmd_cnt_q <= '0;
					ev_cnt_q  <= '0;
					ev_ptr_q  <= '0;
					// address is only valid at the accepting edge
					if (sbs_pkg::op_t'(opcode) == sbs_pkg::OP_START) begin
						start_q <= sbs_pkg::ADDR_W'(address);
					end
					if (sbs_pkg::op_t'(opcode) == sbs_pkg::OP_TICK &&
					    play_q && wait_q != '0) begin
						wait_q <= wait_q - 1'b1;
					end
				end
				sbs_pkg::DP_SIL:     ch_q <= ch_q + 1'b1;
				sbs_pkg::DP_SIL_END: play_q <= 1'b0;
				sbs_pkg::DP_SETUP: begin
					cursor_q <= start_q;
					play_q   <= 1'b1;
				end
				sbs_pkg::DP_DECODE: begin
					case (cls)
						sbs_pkg::CLS_OFF, sbs_pkg::CLS_OTHER:
							cmd_cnt_q <= cmd_cnt_q + 1'b1;
						sbs_pkg::CLS_INSTR: begin
							cursor_q  <= cursor_q + 1'b1;
							cmd_cnt_q <= cmd_cnt_q + 1'b1;
						end
						sbs_pkg::CLS_RESTART: begin
							cursor_q  <= start_q;
							cmd_cnt_q <= cmd_cnt_q + 1'b1;
						end
						sbs_pkg::CLS_STOP: play_q <= 1'b0;
						default: ;
					endcase
				end
				sbs_pkg::DP_WAIT_LO: wait_q <= (wait_val == '0) ? 15'd1 : wait_val;
				sbs_pkg::DP_NOTE: begin
					cursor_q  <= cursor_q + sbs_pkg::ADDR_W'(vol_q);
					cmd_cnt_q <= cmd_cnt_q + 1'b1;
				end
				sbs_pkg::DP_LIMIT: begin
					play_q <= 1'b0;
					ovr_q  <= 1'b1;
				end
				sbs_pkg::DP_DRAIN: begin
					if (stat.ev_more) begin
						ev_ptr_q  <= ev_ptr_q + 1'b1;
						out_ev_s1 <= 1'b1;
					end else begin
						out_st_s1 <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign strobe     = out_ev_s1 | out_st_s1;
	assign last       = out_st_s1;
	assign playing    = play_s1;
	assign overrun    = ovr_s1;
	assign event_kind = out_st_s1 ? sbs_pkg::KIND_STATUS :
		(ev_rd_q.is_off ? sbs_pkg::KIND_OFF : sbs_pkg::KIND_ON);
	assign channel    = out_st_s1 ? 4'd0 : ev_rd_q.chan;
	assign note       = out_st_s1 ? 8'd0 : ev_rd_q.note;

endmodule
`default_nettype wire

// ----- hdl/sbs_checker.sv -----
// Port-level checker of the score byte-stream sequencer and its bind.
`default_nettype none
module sbs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [1:0] event_kind,
	input wire logic [3:0] channel,
	input wire logic [7:0] note,
	input wire logic       last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_gap_after_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word directly after status");

	a_event_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("note event outside an item");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> event_kind == sbs_pkg::KIND_STATUS && channel == 4'd0 && note == 8'd0)
		else $error("malformed status word");

	a_event_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> event_kind == sbs_pkg::KIND_ON ||
			(event_kind == sbs_pkg::KIND_OFF && note == 8'd0))
		else $error("malformed note event");

endmodule

bind score_bytestream_sequencer sbs_checker u_sbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.event_kind (event_kind),
	.channel    (channel),
	.note       (note),
	.last       (last)
);
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the score byte-stream sequencer.
`timescale 1ns / 100ps
module tb;
	import sbs_pkg::*;

	// Run limits. The cycle limit is several times the slowest legal run:
	// a few hundred words, each with a full silence, a full command run and
	// the result drain behind it, plus the sender's longest gaps.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_WORDS = 136;
	localparam int MIN_PHASES   = 4;
	localparam int SETTLE       = 16;

	// High nibbles that the sequencer reads past without acting
	localparam logic [7:0] NIB_SPARE_A = 8'ha0;
	localparam logic [7:0] NIB_SPARE_B = 8'hb0;
	localparam logic [7:0] NIB_SPARE_D = 8'hd0;

	// One result word as it leaves the block
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] chan;
		logic [7:0] note;
		logic       playing;
		logic       overrun;
		logic       last;
	} score_event_t;

	// One row of the directed table. Rows marked typed carry their results
	// in the row itself: offs note-offs on channels 0.. then the status word.
	// All other rows are checked against the predictor.
	typedef struct packed {
		op_t         op;
		logic [11:0] addr;
		logic [7:0]  data;
		logic        typed;
		logic [4:0]  offs;
		logic        play;
		logic        ovr;
	} stim_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic [1:0]  opcode    = '0;
	logic [11:0] address   = '0;
	logic [7:0]  data      = '0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data  = '0;
	logic        busy;
	logic        strobe;
	logic [1:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  note;
	logic        playing;
	logic        overrun;
	logic        last;

	score_bytestream_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.address    (address),
		.data       (data),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.event_kind (event_kind),
		.channel    (channel),
		.note       (note),
		.playing    (playing),
		.overrun    (overrun),
		.last       (last)
	);

	always begin
		#5 clk = 1'b0;
		#5 clk = 1'b1;
	end

	// ---------------------------------------------------------------
	// Predictor state: its own copy of the score and the player
	// ---------------------------------------------------------------
	logic [7:0]   score_mem [SCORE_DEPTH];
	addr_t        play_ptr    = '0;
	addr_t        loop_addr   = '0;
	logic [14:0]  ticks_left  = '0;
	logic         score_on    = 1'b0;
	logic         vol_skip    = 1'b1;
	logic [4:0]   stop_chans  = 5'd3;
	logic         run_overrun = 1'b0;

	score_event_t item_words[$];      // words of the item being predicted
	score_event_t expected_words[$];  // words still owed by the block
	score_event_t got_word;

	int mismatches = 0;
	int cycles     = 0;
	int words_sent = 0;
	int burst_left = 0;

	// Score currently being played, so noise loads can stay clear of it
	logic [7:0]   score_bytes[$];
	logic [11:0]  span_base = '0;
	int           span_len  = 0;

	function automatic logic [7:0] next_score_byte();
		logic [7:0] b;
		b = score_mem[play_ptr];
		play_ptr = play_ptr + 1'b1;  // wraps at the top of the score
		return b;
	endfunction

	task automatic push_event(logic [1:0] kind, logic [3:0] chan, logic [7:0] nt);
		score_event_t e;
		e = '0;
		e.kind = kind;
		e.chan = chan;
		e.note = nt;
		item_words.push_back(e);
	endtask

	// Stop path: note off on every configured channel, capped at sixteen
	task automatic mute_channels();
		int n;
		n = (stop_chans > CHANNEL_MAX) ? CHANNEL_MAX : stop_chans;
		for (int c = 0; c < n; c++)
			push_event(KIND_OFF, 4'(c), 8'h00);
		score_on = 1'b0;
	endtask

	// Walk the score until a wait or a stop, or give up at the command limit
	task automatic interpret_score();
		logic [7:0] cmd;
		logic [7:0] arg;
		for (int done = 0; done < CMD_LIMIT; done++) begin
			cmd = next_score_byte();
			if (!cmd[7]) begin
				arg = next_score_byte();
				ticks_left = {cmd[6:0], arg};
				if (ticks_left == 15'd0)
					ticks_left = 15'd1;
				return;
			end
			case (cmd & HI_MASK)
				NIB_OFF: push_event(KIND_OFF, cmd[3:0], 8'h00);
				NIB_ON: begin
					arg = next_score_byte();
					if (vol_skip)
						void'(next_score_byte());
					push_event(KIND_ON, cmd[3:0], arg);
				end
				NIB_INSTR: void'(next_score_byte());
				NIB_RESTART: play_ptr = loop_addr;
				NIB_STOP: begin
					score_on = 1'b0;
					return;
				end
				default: ;
			endcase
		end
		score_on = 1'b0;
		run_overrun = 1'b1;
	endtask

	// Append the status word, stamp the flags, and queue the item if kept
	task automatic close_item(logic play, logic ovr, logic keep);
		push_event(KIND_STATUS, 4'h0, 8'h00);
		foreach (item_words[k]) begin
			item_words[k].playing = play;
			item_words[k].overrun = ovr;
		end
		item_words[item_words.size() - 1].last = 1'b1;
		if (keep)
			foreach (item_words[k])
				expected_words.push_back(item_words[k]);
	endtask

	task automatic predict_item(op_t op, logic [11:0] a, logic [7:0] d, logic keep);
		item_words.delete();
		run_overrun = 1'b0;
		case (op)
			OP_LOAD: score_mem[a] = d;
			OP_START: begin
				if (score_on)
					mute_channels();
				loop_addr = a;
				play_ptr = a;
				score_on = 1'b1;
				interpret_score();
			end
			OP_STOP: mute_channels();
			OP_TICK: begin
				if (score_on && ticks_left != 15'd0) begin
					ticks_left = ticks_left - 15'd1;
					if (ticks_left == 15'd0)
						interpret_score();
				end
			end
		endcase
		close_item(score_on, run_overrun, keep);
	endtask

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// Hand one word to the block. The sender runs in bursts; a gap ends
	// a burst most of the time. Start stays high across back-to-back words.
	task automatic send_word(op_t op, logic [11:0] a, logic [7:0] d, logic from_model);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		start   <= 1'b1;
		opcode  <= op;
		address <= a;
		data    <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		// taken at the first edge above, while the block was idle
		predict_item(op, a, d, from_model);
		words_sent++;
	endtask

	// Drop start and let every owed word come back before touching registers
	task automatic wait_idle();
		start <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_registers(logic [4:0] vol_word, logic [4:0] chan_word);
		cfg_write <= 1'b1;
		cfg_index <= CFG_VOLUME;
		cfg_data  <= vol_word;
		@(posedge clk);
		cfg_index <= CFG_CHANNELS;
		cfg_data  <= chan_word;
		@(posedge clk);
		cfg_write <= 1'b0;
		vol_skip   = vol_word[0];
		stop_chans = chan_word;
	endtask

	// Score of a few segments, most ending in a wait, closed by a stop or
	// a restart. A restart with no wait in the score loops into overrun.
	task automatic build_score();
		int nseg;
		int ncmd;
		score_bytes.delete();
		nseg = $urandom_range(1, 3);
		repeat (nseg) begin
			ncmd = $urandom_range(0, 3);
			repeat (ncmd) begin
				case ($urandom_range(0, 5))
					0: score_bytes.push_back(NIB_OFF | 8'($urandom_range(0, 15)));
					1, 2: begin
						score_bytes.push_back(NIB_ON | 8'($urandom_range(0, 15)));
						score_bytes.push_back(8'($urandom_range(0, 255)));
						if (vol_skip)
							score_bytes.push_back(8'($urandom_range(0, 255)));
					end
					3: begin
						score_bytes.push_back(NIB_INSTR | 8'($urandom_range(0, 15)));
						score_bytes.push_back(8'($urandom_range(0, 255)));
					end
					4: score_bytes.push_back(NIB_SPARE_A | 8'($urandom_range(0, 15)));
					default: begin
						if ($urandom_range(0, 1))
							score_bytes.push_back(NIB_SPARE_B | 8'($urandom_range(0, 15)));
						else
							score_bytes.push_back(NIB_SPARE_D | 8'($urandom_range(0, 15)));
					end
				endcase
			end
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 5) == 0) begin
					// long wait: outlives the ticks this score will get
					score_bytes.push_back(8'($urandom_range(1, 127)));
					score_bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					score_bytes.push_back(8'h00);
					score_bytes.push_back(8'($urandom_range(0, 3)));
				end
			end
		end
		if ($urandom_range(0, 1))
			score_bytes.push_back(NIB_STOP | 8'($urandom_range(0, 15)));
		else
			score_bytes.push_back(NIB_RESTART | 8'($urandom_range(0, 15)));
	endtask

	// Load to a random address outside the live score
	task automatic noise_load();
		logic [11:0] a;
		do
			a = 12'($urandom_range(0, SCORE_DEPTH - 1));
		while (12'(a - span_base) < span_len);
		send_word(OP_LOAD, a, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Load a fresh score, start it, then feed ticks with some noise mixed in.
	// No ticks go out while loading: the old score may be half overwritten.
	task automatic play_one_score();
		logic [11:0] base;
		build_score();
		base = 12'($urandom_range(0, SCORE_DEPTH - 1));
		span_base = base;
		span_len  = score_bytes.size();
		for (int i = 0; i < span_len; i++) begin
			send_word(OP_LOAD, 12'(base + i), score_bytes[i], 1'b1);
			if ($urandom_range(0, 7) == 0)
				noise_load();
		end
		// otherwise the start may land while the old score is still playing
		if ($urandom_range(0, 2) == 0)
			send_word(OP_STOP, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), 1'b1);
		send_word(OP_START, base, 8'($urandom_range(0, 255)), 1'b1);
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 11))
				0: noise_load();
				1: send_word(OP_STOP, 12'($urandom_range(0, 4095)),
					8'($urandom_range(0, 255)), 1'b1);
				default: send_word(OP_TICK, 12'($urandom_range(0, 4095)),
					8'($urandom_range(0, 255)), 1'b1);
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Directed table. Reset settings: volume byte present, three channels.
	// The score at 0x000 covers note on with the top note, a zero wait,
	// note off on the top channel, instrument skip, the three ignored
	// nibbles and a restart. Later rows cover a score that wraps past the
	// top address, a start while playing, a stop command inside the start
	// run, and a restart loop that hits the command limit.
	// ---------------------------------------------------------------
	stim_row_t directed_rows [24] = '{
		'{OP_TICK,  12'h000, 8'h00, 1'b1, 5'd0, 1'b0, 1'b0},  // idle tick
		'{OP_STOP,  12'h000, 8'h00, 1'b1, 5'd3, 1'b0, 1'b0},  // stop when idle
		'{OP_LOAD,  12'h000, 8'h90, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h001, 8'hff, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h002, 8'h7f, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h003, 8'h00, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h004, 8'h00, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h005, 8'h8f, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h006, 8'hc5, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h007, 8'h42, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h008, 8'ha3, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h009, 8'hb0, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h00a, 8'hd7, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h00b, 8'he0, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_START, 12'h000, 8'hff, 1'b0, 5'd0, 1'b0, 1'b0},
		'{OP_TICK,  12'hfff, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},
		'{OP_START, 12'h000, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},  // start while playing
		'{OP_LOAD,  12'hfff, 8'h81, 1'b1, 5'd0, 1'b1, 1'b0},
		'{OP_START, 12'hfff, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},  // wraps to 0x000
		'{OP_TICK,  12'h000, 8'hff, 1'b0, 5'd0, 1'b0, 1'b0},
		'{OP_LOAD,  12'h800, 8'hff, 1'b1, 5'd0, 1'b1, 1'b0},
		'{OP_START, 12'h800, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0},  // stop command holds
		'{OP_LOAD,  12'h801, 8'he5, 1'b1, 5'd0, 1'b0, 1'b0},
		'{OP_START, 12'h801, 8'h00, 1'b1, 5'd0, 1'b0, 1'b1}   // restart loop overrun
	};

	// ---------------------------------------------------------------
	// Result checking: every strobe word against the oldest expectation
	// ---------------------------------------------------------------
	task automatic check_field(string what, logic [7:0] want, logic [7:0] seen);
		if (seen !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
		end
	endtask

	always @(posedge clk) begin
		if (strobe === 1'b1) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, kind %0h channel %0h note %0h",
					$time, event_kind, channel, note);
			end else begin
				got_word = expected_words.pop_front();
				check_field("event_kind", 8'(got_word.kind), 8'(event_kind));
				check_field("channel", 8'(got_word.chan), 8'(channel));
				check_field("note", got_word.note, note);
				check_field("playing", 8'(got_word.playing), 8'(playing));
				check_field("overrun", 8'(got_word.overrun), 8'(overrun));
				check_field("last", 8'(got_word.last), 8'(last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		stim_row_t row;
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			send_word(row.op, row.addr, row.data, !row.typed);
			if (row.typed) begin
				item_words.delete();
				for (int c = 0; c < row.offs; c++)
					push_event(KIND_OFF, 4'(c), 8'h00);
				close_item(row.play, row.ovr, 1'b1);
			end
		end

		// Random phases, each under its own register settings. Every phase
		// ends with a stop so no tick can run an old score under new settings.
		phase = 0;
		while (phase < MIN_PHASES || words_sent < $size(directed_rows) + RANDOM_WORDS) begin
			wait_idle();
			case (phase)
				0: write_registers(5'h00, 5'd0);
				1: write_registers(5'h1f, 5'd16);
				2: write_registers(5'h1e, 5'd31);
				3: write_registers(5'h01, 5'd1);
				default: write_registers(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			endcase
			repeat (2) play_one_score();
			send_word(OP_STOP, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), 1'b1);
			phase++;
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- score_bytestream_sequencer.f -----
hdl/sbs_pkg.sv
hdl/sbs_ctrl.sv
hdl/sbs_datapath.sv
hdl/score_bytestream_sequencer.sv
hdl/sbs_checker.sv
bench/tb.sv
